[hdl/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// invariant that holds at every clock edge
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/ica_pkg.sv]
package ica_pkg;

   // fixed field widths
   localparam int KIND_W  = 3;
   localparam int OPND_W  = 32;
   localparam int VALUE_W = 48;
   localparam int ERR_W   = 2;

   // parameter defaults
   localparam int DATA_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // factorial: 34! and above wrap to zero; arguments below fit this counter
   localparam int FACT_LIMIT = 34;
   localparam int FACT_CNT_W = 6;

   typedef enum logic [KIND_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_QUOT = 3'd3,
      OP_POW  = 3'd4,
      OP_SQRT = 3'd5,
      OP_FACT = 3'd6,
      OP_MOD  = 3'd7
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIV_ZERO = 2'd1,
      ERR_NEG_ROOT = 2'd2,
      ERR_NEG_FACT = 2'd3
   } err_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic sqrt_step;
      logic pow_mul;
      logic pow_sqr;
      logic fact_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type kind;
      logic   early;
      logic   pow_last;
      logic   fact_last;
   } status_type;

endpackage

[hdl/ica_ifs.sv]
// request channel: operation and operands
interface ica_req_if import ica_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [OPND_W-1:0] operand_a;
   logic signed [OPND_W-1:0] operand_b;

   modport source (output valid, kind, operand_a, operand_b, input ready);
   modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

// response channel: result, format flag and error code
interface ica_rsp_if import ica_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      is_fixed;
   logic [ERR_W-1:0]          error_code;

   modport source (output valid, value, is_fixed, error_code, input ready);
   modport sink   (input valid, value, is_fixed, error_code, output ready);
endinterface

[hdl/integer_calculator_alu_core.sv]
// Channel   Dir  Beat contents
// req_if    in   kind, operand_a, operand_b
// rsp_if    out  value, is_fixed, error_code
//
// One request at a time: accept, evaluate, the unit steps, finish, then the beat
// waits on rsp_if until taken. Results known early (add, sub, mul, errors,
// trivial cases): evaluate and finish share a cycle.
// Quotient and modulus: DATA_BITS+FRAC_BITS divider steps (48 by default).
// Root: (DATA_BITS+2*FRAC_BITS+1)/2 steps (32); power: two multiplier passes per
// exponent bit less one (up to 61); factorial: a-1 multiplier passes (up to 32).
// Synchronous reset returns the controller to idle; a stalled rsp beat holds.
`include "assert_macros.svh"
module integer_calculator_alu_core import ica_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ica_req_if.sink   req_if,
   ica_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_err;

   // sequencer
   ica_ctrl #(
      .DATA_BITS (DATA_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic units and result register
   ica_datapath #(
      .DATA_BITS (DATA_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_if.kind),
      .req_operand_a  (req_if.operand_a),
      .req_operand_b  (req_if.operand_b),
      .rsp_value      (rsp_if.value),
      .rsp_is_fixed   (rsp_if.is_fixed),
      .rsp_error_code (rsp_if.error_code)
   );

   // checks
   assign rsp_err = rsp_if.error_code != ERR_NONE;

   `ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_if.ready && rsp_if.valid))
   `ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_if.valid)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `ASSERT_IMPLY(a_err_zero, clock, reset, rsp_if.valid && rsp_err, rsp_if.value == '0)

endmodule

[hdl/ica_datapath.sv]
module ica_datapath import ica_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [OPND_W-1:0]  req_operand_a,
   input  logic signed [OPND_W-1:0]  req_operand_b,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_is_fixed,
   output logic [ERR_W-1:0]          rsp_error_code
);

   localparam int QW  = DATA_BITS + FRAC_BITS;            // divider dividend width
   localparam int SQ  = (DATA_BITS + 2*FRAC_BITS + 1) / 2; // root bits
   localparam int SXW = 2 * SQ;                             // radicand width
   localparam int RW  = SQ + 2;                             // root remainder width

   // operand registers
   op_type                kind_ff;
   logic [DATA_BITS-1:0]  a_ff, b_ff;
   logic                  neg_ff;
   // divider
   logic [DATA_BITS-1:0]  d_ff, rem_ff;
   logic [QW-1:0]         n_ff;
   // square root
   logic [SXW-1:0]        sx_ff;
   logic [SQ-1:0]         root_ff;
   logic [RW-1:0]         srem_ff;
   // power and factorial
   logic [DATA_BITS-1:0]  acc_ff, base_ff, pe_ff;
   logic [FACT_CNT_W-1:0] fi_ff;
   // result
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  fixed_ff;
   err_type               err_ff, err_in;

   logic [DATA_BITS-1:0]  a_in, b_in, a_mag, b_mag;
   logic [DATA_BITS:0]    div_t;
   logic [RW-1:0]         sq_cur, sq_trial;
   logic [DATA_BITS-1:0]  mul_x, mul_y, prod;
   logic                  early;
   logic [DATA_BITS-1:0]  sval;
   err_type               serr;
   logic [VALUE_W-1:0]    q48, iter_val;
   logic [DATA_BITS-1:0]  mod_val;

   // incoming operands, truncated to the working width
   assign a_in  = req_operand_a[DATA_BITS-1:0];
   assign b_in  = req_operand_b[DATA_BITS-1:0];
   assign a_mag = a_in[DATA_BITS-1] ? DATA_BITS'(0) - a_in : a_in;
   assign b_mag = b_in[DATA_BITS-1] ? DATA_BITS'(0) - b_in : b_in;

   // restoring divide: one quotient bit a step
   assign div_t = {rem_ff, n_ff[QW-1]};

   // digit-by-digit root: two radicand bits a step
   assign sq_cur   = {srem_ff[RW-3:0], sx_ff[SXW-1:SXW-2]};
   assign sq_trial = {root_ff, 2'b01};

   // shared multiplier, low half only
   always_comb begin
      if (cmd.pow_sqr) begin
         mul_x = base_ff;
         mul_y = base_ff;
      end else if (cmd.pow_mul) begin
         mul_x = acc_ff;
         mul_y = base_ff;
      end else if (cmd.fact_step) begin
         mul_x = acc_ff;
         mul_y = DATA_BITS'(fi_ff);
      end else begin
         mul_x = a_ff;
         mul_y = b_ff;
      end
   end
   assign prod = DATA_BITS'(mul_x * mul_y);

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= op_type'(req_kind);
         a_ff    <= a_in;
         b_ff    <= b_in;
         neg_ff  <= (op_type'(req_kind) == OP_QUOT) ? (a_in[DATA_BITS-1] ^ b_in[DATA_BITS-1])
                                                    : a_in[DATA_BITS-1];
         d_ff    <= b_mag;
         rem_ff  <= '0;
         n_ff    <= (op_type'(req_kind) == OP_MOD) ? QW'(a_mag) : (QW'(a_mag) << FRAC_BITS);
         sx_ff   <= SXW'(a_in) << (2*FRAC_BITS);
         root_ff <= '0;
         srem_ff <= '0;
         acc_ff  <= DATA_BITS'(1);
         base_ff <= a_in;
         pe_ff   <= b_in;
         fi_ff   <= FACT_CNT_W'(2);
      end
      if (cmd.div_step) begin
         if (div_t >= {1'b0, d_ff}) begin
            rem_ff <= DATA_BITS'(div_t - {1'b0, d_ff});
            n_ff   <= {n_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= div_t[DATA_BITS-1:0];
            n_ff   <= {n_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.sqrt_step) begin
         sx_ff <= sx_ff << 2;
         if (sq_cur >= sq_trial) begin
            srem_ff <= sq_cur - sq_trial;
            root_ff <= {root_ff[SQ-2:0], 1'b1};
         end else begin
            srem_ff <= sq_cur;
            root_ff <= {root_ff[SQ-2:0], 1'b0};
         end
      end
      if (cmd.pow_mul) begin
         if (pe_ff[0]) begin
            acc_ff <= prod;
         end
         pe_ff <= pe_ff >> 1;
      end
      if (cmd.pow_sqr) begin
         base_ff <= prod;
      end
      if (cmd.fact_step) begin
         acc_ff <= prod;
         fi_ff  <= fi_ff + FACT_CNT_W'(1);
      end
   end

   // results known straight from the operands
   always_comb begin
      early = 1'b0;
      sval  = '0;
      serr  = ERR_NONE;
      unique case (kind_ff) inside
         OP_ADD: begin
            early = 1'b1;
            sval  = a_ff + b_ff;
         end
         OP_SUB: begin
            early = 1'b1;
            sval  = a_ff - b_ff;
         end
         OP_MUL: begin
            early = 1'b1;
            sval  = prod;
         end
         OP_QUOT, OP_MOD: begin
            if (b_ff == '0) begin
               early = 1'b1;
               serr  = ERR_DIV_ZERO;
            end
         end
         OP_POW: begin
            if (b_ff[DATA_BITS-1]) begin
               // negative exponent: truncated reciprocal
               early = 1'b1;
               if (a_ff == '0) begin
                  serr = ERR_DIV_ZERO;
               end else if (a_ff == DATA_BITS'(1)) begin
                  sval = DATA_BITS'(1);
               end else if (a_ff == '1) begin
                  sval = b_ff[0] ? '1 : DATA_BITS'(1);
               end
            end else if (b_ff == '0) begin
               early = 1'b1;
               sval  = DATA_BITS'(1);
            end
         end
         OP_SQRT: begin
            if (a_ff[DATA_BITS-1]) begin
               early = 1'b1;
               serr  = ERR_NEG_ROOT;
            end
         end
         OP_FACT: begin
            if (a_ff[DATA_BITS-1]) begin
               early = 1'b1;
               serr  = ERR_NEG_FACT;
            end else if (a_ff >= DATA_BITS'(FACT_LIMIT)) begin
               early = 1'b1;
            end else if (a_ff < DATA_BITS'(2)) begin
               early = 1'b1;
               sval  = DATA_BITS'(1);
            end
         end
      endcase
   end

   // results of the iterating units
   assign q48     = VALUE_W'(n_ff);
   assign mod_val = neg_ff ? DATA_BITS'(0) - rem_ff : rem_ff;

   always_comb begin
      case (kind_ff)
         OP_QUOT: begin
            if (!neg_ff && q48[VALUE_W-1]) begin
               iter_val = {1'b0, {(VALUE_W-1){1'b1}}};
            end else begin
               iter_val = neg_ff ? VALUE_W'(0) - q48 : q48;
            end
         end
         OP_MOD:  iter_val = VALUE_W'(signed'(mod_val));
         OP_SQRT: iter_val = VALUE_W'(root_ff);
         default: iter_val = VALUE_W'(signed'(acc_ff));
      endcase
   end

   assign value_in = early ? VALUE_W'(signed'(sval)) : iter_val;
   assign err_in   = early ? serr : ERR_NONE;

   // output register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         value_ff <= value_in;
         fixed_ff <= (kind_ff == OP_QUOT) || (kind_ff == OP_SQRT);
         err_ff   <= err_in;
      end
   end

   assign rsp_value      = signed'(value_ff);
   assign rsp_is_fixed   = fixed_ff;
   assign rsp_error_code = err_ff;

   assign status.kind      = kind_ff;
   assign status.early     = early;
   assign status.pow_last  = (pe_ff >> 1) == '0;
   assign status.fact_last = fi_ff == a_ff[FACT_CNT_W-1:0];

endmodule

[hdl/ica_ctrl.sv]
module ica_ctrl import ica_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int DIV_STEPS  = DATA_BITS + FRAC_BITS;
   localparam int SQRT_STEPS = (DATA_BITS + 2*FRAC_BITS + 1) / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_EVAL = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_SQRT = 9'b000001000,
      S_PMUL = 9'b000010000,
      S_PSQR = 9'b000100000,
      S_FACT = 9'b001000000,
      S_FIN  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.early) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               unique case (status.kind) inside
                  OP_QUOT, OP_MOD: begin
                     state_in = S_DIV;
                     cnt_in   = CNT_W'(DIV_STEPS - 1);
                  end
                  OP_SQRT: begin
                     state_in = S_SQRT;
                     cnt_in   = CNT_W'(SQRT_STEPS - 1);
                  end
                  OP_POW:  state_in = S_PMUL;
                  OP_FACT: state_in = S_FACT;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_PMUL: begin
            cmd.pow_mul = 1'b1;
            state_in    = status.pow_last ? S_FIN : S_PSQR;
         end
         S_PSQR: begin
            cmd.pow_sqr = 1'b1;
            state_in    = S_PMUL;
         end
         S_FACT: begin
            cmd.fact_step = 1'b1;
            if (status.fact_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
